FILE: rtl/bcbb_pkg.sv
// Shared types and constants for the blob centroid and bounding box core.
package bcbb_pkg;

    localparam int PIX_W       = 12;
    localparam int MARGIN_W    = 4;
    localparam int CTR_W       = 16;
    localparam int BOX_W       = 13;
    localparam int USED_W      = 9;
    localparam int FRAC_W      = 4;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 96;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (2 * CTR_W + 4 * BOX_W + USED_W);

    localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(3);

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_LOAD,
        ST_DIVIDE,
        ST_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // take the input beat into the accumulators
        logic div_start;  // load both dividers from the accumulators
        logic out_load;   // capture the result and clear the accumulators
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
    } t_sts;

endpackage

FILE: rtl/bcbb_div.sv
// Restoring bit-serial divider, one quotient bit per cycle.
module bcbb_div #(
    parameter int NUM_W = 29,
    parameter int DEN_W = 9
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [NUM_W-1:0]          i_num,
    input  logic [DEN_W-1:0]          i_den,
    output logic [bcbb_pkg::CTR_W-1:0] o_quo,
    output logic                      o_done
);
    import bcbb_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [NUM_W-1:0] r_num, n_num;
    logic [DEN_W-1:0] r_den, n_den;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [CTR_W-1:0] r_quo, n_quo;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {r_rem, r_num[NUM_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_comb begin
        n_cnt = r_cnt;
        n_num = r_num;
        n_den = r_den;
        n_rem = r_rem;
        n_quo = r_quo;
        if (i_start) begin
            n_cnt = CNT_W'(NUM_W);
            n_num = i_num;
            n_den = i_den;
            n_rem = '0;
            n_quo = '0;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - CNT_W'(1);
            n_num = {r_num[NUM_W-2:0], 1'b0};
            n_rem = fits ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
            n_quo = {r_quo[CTR_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_num <= n_num;
        r_den <= n_den;
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_quo  = r_quo;
    assign o_done = (r_cnt == '0);

endmodule

FILE: rtl/bcbb_dp.sv
// Datapath: accumulators, margin register, dividers and result register.
module bcbb_dp #(
    parameter int MAX_POINTS = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bcbb_pkg::t_cmd                     i_cmd,
    output bcbb_pkg::t_sts                     o_sts,
    input  logic [bcbb_pkg::PIX_W-1:0]         i_pixel_x,
    input  logic [bcbb_pkg::PIX_W-1:0]         i_pixel_y,
    input  logic                               i_cfg_we,
    input  logic [bcbb_pkg::MARGIN_W-1:0]      i_cfg_wdata,
    output logic [bcbb_pkg::OUT_TDATA_W-1:0]   o_tdata,
    output logic                               o_dropped
);
    import bcbb_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int SUM_W = PIX_W + CNT_W;
    localparam int NUM_W = SUM_W + FRAC_W;

    logic [MARGIN_W-1:0] r_margin;
    logic [SUM_W-1:0]    r_sum_x, r_sum_y;
    logic [PIX_W-1:0]    r_min_x, r_min_y, r_max_x, r_max_y;
    logic [CNT_W-1:0]    r_count;
    logic                r_over;
    logic [OUT_TDATA_W-1:0] r_tdata;
    logic                r_dropped;

    logic                full;
    logic [CTR_W-1:0]    quo_x, quo_y;
    logic                done_x, done_y;
    logic [CTR_W-1:0]    cen_x, cen_y;
    logic [BOX_W-1:0]    left, top, wid, hgt, twice_m;

    assign full = (r_count == CNT_W'(MAX_POINTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= MARGIN_RESET;
        end else if (i_cfg_we) begin
            r_margin <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_min_x <= '0;
            r_min_y <= '0;
            r_max_x <= '0;
            r_max_y <= '0;
            r_count <= '0;
            r_over  <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_min_x <= '0;
            r_min_y <= '0;
            r_max_x <= '0;
            r_max_y <= '0;
            r_count <= '0;
            r_over  <= 1'b0;
        end else if (i_cmd.accept) begin
            if (full) begin
                r_over <= 1'b1;
            end else begin
                r_sum_x <= r_sum_x + SUM_W'(i_pixel_x);
                r_sum_y <= r_sum_y + SUM_W'(i_pixel_y);
                r_count <= r_count + CNT_W'(1);
                if (r_count == '0) begin
                    r_min_x <= i_pixel_x;
                    r_max_x <= i_pixel_x;
                    r_min_y <= i_pixel_y;
                    r_max_y <= i_pixel_y;
                end else begin
                    if (i_pixel_x < r_min_x) r_min_x <= i_pixel_x;
                    if (i_pixel_x > r_max_x) r_max_x <= i_pixel_x;
                    if (i_pixel_y < r_min_y) r_min_y <= i_pixel_y;
                    if (i_pixel_y > r_max_y) r_max_y <= i_pixel_y;
                end
            end
        end
    end

    bcbb_div #(.NUM_W(NUM_W), .DEN_W(CNT_W)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   ({r_sum_x, FRAC_W'(0)}),
        .i_den   (r_count),
        .o_quo   (quo_x),
        .o_done  (done_x)
    );

    bcbb_div #(.NUM_W(NUM_W), .DEN_W(CNT_W)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   ({r_sum_y, FRAC_W'(0)}),
        .i_den   (r_count),
        .o_quo   (quo_y),
        .o_done  (done_y)
    );

    assign o_sts.div_done = done_x & done_y;

    // An empty blob yields a zero centroid.
    assign cen_x   = (r_count == '0) ? '0 : quo_x;
    assign cen_y   = (r_count == '0) ? '0 : quo_y;
    assign twice_m = BOX_W'({r_margin, 1'b0});
    assign left    = BOX_W'(r_min_x) - BOX_W'(r_margin);
    assign top     = BOX_W'(r_min_y) - BOX_W'(r_margin);
    assign wid     = BOX_W'(r_max_x) - BOX_W'(r_min_x) + twice_m;
    assign hgt     = BOX_W'(r_max_y) - BOX_W'(r_min_y) + twice_m;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_tdata   <= {OUT_PAD_W'(0), USED_W'(r_count), hgt, wid, top, left, cen_y, cen_x};
            r_dropped <= r_over;
        end
    end

    assign o_tdata   = r_tdata;
    assign o_dropped = r_dropped;

endmodule

FILE: rtl/bcbb_ctrl.sv
// Controller state machine: accept beats, sequence the division, hand off the result.
module bcbb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    input  logic           i_s_tlast,
    output logic           o_s_tready,
    input  logic           i_m_tready,
    output logic           o_m_tvalid,
    input  bcbb_pkg::t_sts i_sts,
    output bcbb_pkg::t_cmd o_cmd
);
    import bcbb_pkg::*;

    t_state r_state, n_state;
    logic   r_m_valid, n_m_valid;
    logic   out_free;

    assign out_free = !r_m_valid || i_m_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_COLLECT: if (i_s_tvalid && i_s_tlast) n_state = ST_LOAD;
            ST_LOAD:    n_state = ST_DIVIDE;
            ST_DIVIDE:  if (i_sts.div_done) n_state = ST_FINISH;
            ST_FINISH:  if (out_free) n_state = ST_COLLECT;
            default:    n_state = ST_COLLECT;
        endcase
    end

    always_comb begin
        o_s_tready      = 1'b0;
        o_cmd.accept    = 1'b0;
        o_cmd.div_start = 1'b0;
        o_cmd.out_load  = 1'b0;
        case (r_state)
            ST_COLLECT: begin
                o_s_tready   = 1'b1;
                o_cmd.accept = i_s_tvalid;
            end
            ST_LOAD:   o_cmd.div_start = 1'b1;
            ST_DIVIDE: ;
            ST_FINISH: o_cmd.out_load = out_free;
            default:   ;
        endcase
    end

    always_comb begin
        n_m_valid = r_m_valid;
        if (o_cmd.out_load) begin
            n_m_valid = 1'b1;
        end else if (i_m_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_COLLECT;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_m_tvalid = r_m_valid;

endmodule

FILE: rtl/blob_centroid_bounding_box_core.sv
// Top level of the blob centroid and bounding box core.
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tdata: pixel_x, pixel_y; tlast: last_point
//  m_axis    out  m_axis_tvalid/tready       tdata: centroid, box, points_used;
//                                            tuser: points_dropped
//  cfg       in   i_cfg_we (no wait)         i_cfg_wdata: box_margin
//
// A pixel beat without tlast is taken at once, so such beats stream back to back.
// A beat with tlast starts two serial dividers (one quotient bit per cycle over the
// SUM_W+4 bit dividend); the input stalls through the load, divide and finish states.
// The result sits in an output register; a waiting result holds the next blob at the
// end of its division, with the input stalled until the register drains.
// Synchronous active-low reset clears the accumulators and loads a margin of 3.
module blob_centroid_bounding_box_core #(
    parameter int MAX_POINTS = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // [11:0] pixel_x, [23:12] pixel_y
    input  logic [bcbb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tlast,
    output logic                                s_axis_tready,
    // [15:0] center_x, [31:16] center_y, [44:32] box_left, [57:45] box_top,
    // [70:58] box_width, [83:71] box_height, [92:84] points_used, [95:93] zero
    output logic [bcbb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // [0] points_dropped
    output logic                                m_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                i_cfg_we,
    input  logic [bcbb_pkg::MARGIN_W-1:0]       i_cfg_wdata
);
    import bcbb_pkg::*;

    t_cmd cmd;
    t_sts sts;

    bcbb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tlast  (s_axis_tlast),
        .o_s_tready (s_axis_tready),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath holds the accumulators, the dividers and the result register.
    bcbb_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_pixel_x   (s_axis_tdata[PIX_W-1:0]),
        .i_pixel_y   (s_axis_tdata[2*PIX_W-1:PIX_W]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_tdata     (m_axis_tdata),
        .o_dropped   (m_axis_tuser)
    );

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the blob centroid and bounding box core.
module tb;
    import bcbb_pkg::*;

    localparam int MAX_POINTS = 256;
    localparam int SETTLE     = 40;    // settling time after a drain, covers a division
    localparam int IDLE_LIMIT = 3000;  // longest hold-off plus division plus drain, with room
    localparam int LONG_HOLD  = 300;

    // One expected blob summary, at the widths of the output fields.
    typedef struct packed {
        logic [CTR_W-1:0]  center_x;
        logic [CTR_W-1:0]  center_y;
        logic [BOX_W-1:0]  box_left;
        logic [BOX_W-1:0]  box_top;
        logic [BOX_W-1:0]  box_width;
        logic [BOX_W-1:0]  box_height;
        logic [USED_W-1:0] points_used;
        logic              points_dropped;
    } t_blob_result;

    // Running model of the accumulators plus the queue of blob summaries still owed.
    class blob_tracker;
        logic [MARGIN_W-1:0] margin;
        logic [31:0]         col_sum;
        logic [31:0]         row_sum;
        logic [PIX_W-1:0]    col_lo, col_hi, row_lo, row_hi;
        int unsigned         count;
        logic                dropped;
        t_blob_result        blobs_due[$];
        int unsigned         mismatches;
        int unsigned         blobs_seen;
        int unsigned         blobs_with_drop;

        function new();
            margin = MARGIN_RESET;
            mismatches = 0;
            blobs_seen = 0;
            blobs_with_drop = 0;
            clear();
        endfunction

        function void clear();
            col_sum = '0;
            row_sum = '0;
            col_lo  = '0;
            col_hi  = '0;
            row_lo  = '0;
            row_hi  = '0;
            count   = 0;
            dropped = 1'b0;
        endfunction

        function void set_margin(logic [MARGIN_W-1:0] m);
            margin = m;
        endfunction

        function int unsigned pending();
            return blobs_due.size();
        endfunction

        // Fold one accepted pixel beat in; on the last beat, close out the blob.
        function void take_pixel(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y, logic last);
            t_blob_result r;
            if (count >= MAX_POINTS) begin
                dropped = 1'b1;
            end else begin
                if (count == 0) begin
                    col_lo = x;
                    col_hi = x;
                    row_lo = y;
                    row_hi = y;
                end else begin
                    if (x < col_lo) col_lo = x;
                    if (x > col_hi) col_hi = x;
                    if (y < row_lo) row_lo = y;
                    if (y > row_hi) row_hi = y;
                end
                col_sum += 32'(x);
                row_sum += 32'(y);
                count++;
            end
            if (!last) return;
            r.center_x       = (count == 0) ? '0 : CTR_W'((col_sum << FRAC_W) / count);
            r.center_y       = (count == 0) ? '0 : CTR_W'((row_sum << FRAC_W) / count);
            r.box_left       = BOX_W'(col_lo) - BOX_W'(margin);
            r.box_top        = BOX_W'(row_lo) - BOX_W'(margin);
            r.box_width      = BOX_W'(col_hi - col_lo) + BOX_W'(2 * margin);
            r.box_height     = BOX_W'(row_hi - row_lo) + BOX_W'(2 * margin);
            r.points_used    = USED_W'(count);
            r.points_dropped = dropped;
            blobs_due.push_back(r);
            clear();
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= 10) $display("[%0t] MISMATCH %s", $time, what);
        endfunction

        function void cmp_field(string name, int unsigned want, int unsigned got);
            if (want != got)
                report($sformatf("%s: expected 0x%0h, got 0x%0h", name, want, got));
        endfunction

        // Compare one delivered blob summary against the oldest one owed.
        function void check_blob(logic [OUT_TDATA_W-1:0] tdata, logic tuser);
            t_blob_result want;
            if (blobs_due.size() == 0) begin
                report($sformatf("unexpected result beat tdata=0x%0h tuser=%0b", tdata, tuser));
                return;
            end
            want = blobs_due.pop_front();
            blobs_seen++;
            if (want.points_dropped) blobs_with_drop++;
            cmp_field("center_x",       want.center_x,       tdata[15:0]);
            cmp_field("center_y",       want.center_y,       tdata[31:16]);
            cmp_field("box_left",       want.box_left,       tdata[44:32]);
            cmp_field("box_top",        want.box_top,        tdata[57:45]);
            cmp_field("box_width",      want.box_width,      tdata[70:58]);
            cmp_field("box_height",     want.box_height,     tdata[83:71]);
            cmp_field("points_used",    want.points_used,    tdata[92:84]);
            cmp_field("points_dropped", want.points_dropped, tuser);
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [11:0] pixel_x, [23:12] pixel_y
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tlast = 1'b0;
    logic                   s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // centroid, box, points_used, pad
    logic                   m_axis_tuser;        // [0] points_dropped
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [MARGIN_W-1:0]    i_cfg_wdata = '0;

    blob_tracker tracker;
    int unsigned pixel_beats = 0;
    int unsigned idle_cycles = 0;
    int unsigned burst_left = 0;
    int unsigned gap_ceiling = 6;
    bit          hold_req = 1'b0;

    blob_centroid_bounding_box_core #(.MAX_POINTS(MAX_POINTS)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Sample both channels at the rising edge; inputs only move at the falling edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                tracker.take_pixel(s_axis_tdata[11:0], s_axis_tdata[23:12], s_axis_tlast);
                pixel_beats++;
            end
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_blob(m_axis_tdata, m_axis_tuser);
        end
    end

    // Watchdog: bail out if neither channel moves a beat for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[%0t] watchdog: no beat for %0d cycles", $time, IDLE_LIMIT);
            $display("tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: switch among random stall patterns; honor a long hold-off on request.
    int unsigned rx_cycle = 0;
    int unsigned rx_mode = 0;
    int unsigned hold_left = 0;
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
        rx_cycle++;
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready = 1'b0;
        end else begin
            case (rx_mode)
                0: m_axis_tready = 1'b1;                            // no stalls
                1: m_axis_tready = $urandom_range(0, 1);            // coin flip
                2: m_axis_tready = (rx_cycle % 4 == 3);             // one in four
                default: m_axis_tready = ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // Hold valid low between bursts; burst and gap lengths are random.
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, gap_ceiling);
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
    endtask

    // Offer one pixel beat and hold it until the block takes it.
    task automatic send_pixel(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y, logic last);
        pace_sender();
        @(negedge i_clk);
        s_axis_tdata  = {y, x};
        s_axis_tlast  = last;
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Stop offering, wait for every owed summary, then let the divider settle.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        s_axis_tlast  = 1'b0;
        burst_left = 0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_margin(logic [MARGIN_W-1:0] m);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = m;
        tracker.set_margin(m);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Coordinate generator: uniform, corner values, or clustered around a center.
    function automatic logic [PIX_W-1:0] pick_coord(int unsigned style, logic [PIX_W-1:0] hub,
                                                    int unsigned spread);
        int signed v;
        case (style)
            0: return PIX_W'($urandom);
            1: begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return '1;
                    2: return PIX_W'(1);
                    default: return PIX_W'(4094);
                endcase
            end
            default: begin
                v = int'(hub) + $urandom_range(0, 2 * spread) - int'(spread);
                if (v < 0) v = 0;
                if (v > 4095) v = 4095;
                return PIX_W'(v);
            end
        endcase
    endfunction

    task automatic send_blob(int unsigned len);
        int unsigned      style;
        int unsigned      spread;
        logic [PIX_W-1:0] hub_x, hub_y;
        style  = ($urandom_range(0, 9) < 2) ? $urandom_range(0, 1) : 2;
        spread = $urandom_range(0, 40);
        hub_x  = PIX_W'($urandom);
        hub_y  = PIX_W'($urandom);
        for (int unsigned i = 0; i < len; i++)
            send_pixel(pick_coord(style, hub_x, spread), pick_coord(style, hub_y, spread),
                       i == len - 1);
    endtask

    // Mostly small blobs, a few long ones near or past capacity.
    task automatic send_random_blobs(int unsigned n_pixels);
        int unsigned sent;
        int unsigned len;
        int unsigned r;
        sent = 0;
        while (sent < n_pixels) begin
            r = $urandom_range(0, 99);
            if (r < 70)      len = $urandom_range(1, 8);
            else if (r < 92) len = $urandom_range(9, 40);
            else if (r < 98) len = $urandom_range(41, 120);
            else             len = $urandom_range(MAX_POINTS - 2, MAX_POINTS + 6);
            send_blob(len);
            sent += len;
        end
    endtask

    initial begin
        tracker = new();
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed, reset margin of 3: corners, alternating bits, fractional centroid.
        send_pixel(12'd0, 12'd0, 1'b1);
        send_pixel(12'hFFF, 12'hFFF, 1'b1);
        send_pixel(12'hFFF, 12'd0, 1'b0);
        send_pixel(12'd0, 12'hFFF, 1'b1);
        send_pixel(12'hAAA, 12'h555, 1'b0);
        send_pixel(12'h555, 12'hAAA, 1'b1);
        send_pixel(12'd7, 12'd9, 1'b0);
        send_pixel(12'd7, 12'd9, 1'b0);
        send_pixel(12'd8, 12'd10, 1'b1);
        drain();

        // Margin at its top: most negative left/top and widest box.
        write_margin(4'd15);
        send_pixel(12'd0, 12'd0, 1'b1);
        send_pixel(12'hFFF, 12'hFFF, 1'b0);
        send_pixel(12'd0, 12'd0, 1'b1);
        send_pixel(12'd14, 12'd15, 1'b1);
        // Exactly full, then one point over with the overflow on the last beat.
        send_blob(MAX_POINTS);
        send_blob(MAX_POINTS + 1);
        send_random_blobs(200);
        drain();

        // Margin zero, with a single-point blob and sender gaps turned off for a while.
        write_margin(4'd0);
        send_pixel(12'd0, 12'hFFF, 1'b1);
        send_pixel(12'd3, 12'd1, 1'b1);
        gap_ceiling = 0;
        send_random_blobs(120);
        gap_ceiling = 6;
        send_random_blobs(120);
        drain();

        // Long receiver hold-off while short blobs keep coming, so the input backs up.
        write_margin(MARGIN_W'($urandom_range(1, 14)));
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++) send_blob($urandom_range(1, 4));
        send_random_blobs(200);
        drain();

        write_margin(MARGIN_W'($urandom_range(0, 15)));
        gap_ceiling = 20;
        send_random_blobs(180);
        drain();

        $display("covered %0d pixel beats and %0d blob summaries, %0d of them over capacity,",
                 pixel_beats, tracker.blobs_seen, tracker.blobs_with_drop);
        $display("margins 3, 15, 0 and two random ones; %0d mismatches", tracker.mismatches);
        if (tracker.mismatches == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
